>>> sv/gbe_pkg.sv
package gbe_pkg;

   localparam int ADDR_BITS = 5;
   localparam int SIDE_REG_BITS = 7;
   localparam int ORIGIN_BITS = 10;
   localparam int COORD_BITS = 11;
   localparam int COLOR_FIELD_BITS = 24;

   localparam logic [COLOR_FIELD_BITS-1:0] FORE_RESET = 24'h000000;
   localparam logic [COLOR_FIELD_BITS-1:0] BACK_RESET = 24'hFFF1C0;
   localparam logic [SIDE_REG_BITS-1:0] SIDE_RESET = 7'd8;

   localparam logic [2:0] REG_ORIGIN_X = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [2:0] REG_GLYPH_WIDTH = 3'd2;
   localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd3;
   localparam logic [2:0] REG_FORE_COLOR = 3'd4;
   localparam logic [2:0] REG_BACK_COLOR = 3'd5;

   typedef struct packed {
      logic       start;
      logic [7:0] bits;
   } gbe_item_type;

   typedef struct packed {
      logic [ORIGIN_BITS-1:0]      origin_x;
      logic [ORIGIN_BITS-1:0]      origin_y;
      logic [SIDE_REG_BITS-1:0]    width;
      logic [SIDE_REG_BITS-1:0]    height;
      logic [COLOR_FIELD_BITS-1:0] fore;
      logic [COLOR_FIELD_BITS-1:0] back;
   } gbe_cfg_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]       x;
      logic [COORD_BITS-1:0]       y;
      logic [COLOR_FIELD_BITS-1:0] color;
      logic                        run_last;
      logic                        glyph_last;
   } gbe_pixel_type;

endpackage

>>> sv/gbe_queue.sv
module gbe_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  gbe_pkg::gbe_item_type in_item,
   output logic                 out_valid,
   input  logic                 out_pop,
   output gbe_pkg::gbe_item_type out_item
);
   import gbe_pkg::*;

   gbe_item_type entries_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = entries_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_pop;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ff] <= in_item;
      end
   end

endmodule

>>> sv/gbe_back.sv
module gbe_back #(
   parameter int MAX_SIDE = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gbe_pkg::gbe_cfg_type   cfg,
   input  logic                   q_valid,
   output logic                   q_pop,
   input  gbe_pkg::gbe_item_type  q_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output gbe_pkg::gbe_pixel_type out_pixel
);
   import gbe_pkg::*;

   localparam int CW = $clog2(MAX_SIDE);
   localparam int SW = $clog2(MAX_SIDE + 1);
   localparam int PW = $clog2(MAX_SIDE * MAX_SIDE + 1);

   function automatic logic [SW-1:0] clamp_side(input logic [SIDE_REG_BITS-1:0] v);
      if (v == '0) begin
         return SW'(1);
      end else if (32'(v) > MAX_SIDE) begin
         return SW'(MAX_SIDE);
      end else begin
         return SW'(v);
      end
   endfunction

   logic            cur_valid_ff, cur_valid_in;
   logic [7:0]      cur_bits_ff, cur_bits_in;
   logic [2:0]      bit_ff, bit_in;
   logic [PW-1:0]   count_ff, count_in;
   logic [CW-1:0]   col_ff, col_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic            rsp_valid_ff, rsp_valid_in;
   gbe_pixel_type   pixel_ff, pixel_in;

   logic [SW-1:0]   w, h;
   logic [PW-1:0]   total;
   logic            done_glyph, out_free, emit, final_px, last_px, finish, wrap;

   assign w          = clamp_side(cfg.width);
   assign h          = clamp_side(cfg.height);
   assign total      = PW'(PW'(w) * PW'(h));
   assign done_glyph = (count_ff >= total);
   assign out_free   = !rsp_valid_ff || out_ready;
   assign emit       = cur_valid_ff && !done_glyph && out_free;
   assign final_px   = (PW'(count_ff + PW'(1)) == total);
   assign last_px    = (bit_ff == 3'd0) || final_px;
   assign finish     = cur_valid_ff && (done_glyph || (emit && last_px));
   assign q_pop      = q_valid && (!cur_valid_ff || finish);
   assign wrap       = ((SW + 1)'(col_ff) + (SW + 1)'(1)) >= (SW + 1)'(w);

   assign out_valid  = rsp_valid_ff;
   assign out_pixel  = pixel_ff;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_bits_in  = cur_bits_ff;
      bit_in       = bit_ff;
      count_in     = count_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff;
      pixel_in     = pixel_ff;

      if (emit) begin
         count_in = PW'(count_ff + PW'(1));
         bit_in   = bit_ff - 3'd1;
         if (!final_px) begin
            if (wrap) begin
               col_in = '0;
               row_in = row_ff + COORD_BITS'(1);
            end else begin
               col_in = CW'(col_ff + CW'(1));
            end
         end
         pixel_in.x          = COORD_BITS'(cfg.origin_x) + COORD_BITS'(col_ff);
         pixel_in.y          = COORD_BITS'(cfg.origin_y) + row_ff;
         pixel_in.color      = cur_bits_ff[bit_ff] ? cfg.fore : cfg.back;
         pixel_in.run_last   = last_px;
         pixel_in.glyph_last = final_px;
         rsp_valid_in        = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end

      // a new word restarts the bit walk; a start word also restarts the glyph
      if (q_pop) begin
         cur_valid_in = 1'b1;
         cur_bits_in  = q_item.bits;
         bit_in       = 3'd7;
         if (q_item.start) begin
            count_in = '0;
            col_in   = '0;
            row_in   = '0;
         end
      end else if (finish) begin
         cur_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         bit_ff       <= 3'd7;
         count_ff     <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         bit_ff       <= bit_in;
         count_ff     <= count_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_bits_ff <= cur_bits_in;
      pixel_ff    <= pixel_in;
   end

   a_glyph_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && pixel_ff.glyph_last) |-> pixel_ff.run_last)
      else $error("glyph_last pixel not marked as end of run");

   a_final_completes: assert property (@(posedge clock) disable iff (reset)
      (emit && final_px && !(q_pop && q_item.start)) |=> (count_ff >= total))
      else $error("pixel count did not reach glyph size after final pixel");

   a_word_continues: assert property (@(posedge clock) disable iff (reset)
      (emit && !last_px) |=> (cur_valid_ff && rsp_valid_ff))
      else $error("word dropped before its last pixel");

endmodule

>>> sv/glyph_bitmap_expander.sv
// Glyph bitmap expander: turns packed 1-bit glyph bitmap words into pixel writes.
// req channel: one bitmap byte per word in req_tdata, most significant bit first;
// req_tuser high marks the first byte of a new glyph and restarts pixel numbering.
// rsp channel: one pixel per word (x, y, color), rsp_tlast on the last pixel of a
// byte, rsp_tuser on the final pixel of the glyph. Bytes after the glyph is
// complete give no pixels.
// csr port: APB-style, registers at 4*i (origin_x, origin_y, glyph_width,
// glyph_height, fore_color, back_color_reg); write only while the block is idle.
// A byte is registered in the input queue, then in the engine's word register, and
// each pixel in the output register. Throughput: one pixel per cycle on rsp while
// rsp_tready holds, set by the single pixel engine behind a two-word input queue;
// consecutive bytes stream without gaps. A byte that gives no pixels is dropped.
// When the receiver stalls, the current pixel holds in the output register, the
// engine waits and the queue fills, then req_tready drops.
// Reset (synchronous, active high) empties the queue and the engine, clears the
// pixel position and returns the registers to their reset values.
module glyph_bitmap_expander #(
   parameter int MAX_SIDE = 64,
   parameter int COLOR_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] glyph_byte
   input  logic                         req_tuser,   // [0] start_req
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [47:0]                  rsp_tdata,   // [10:0] pixel_x, [21:11] pixel_y,
                                                     // [45:22] pixel_color, [47:46] zero
   output logic                         rsp_tlast,   // run_last
   output logic                         rsp_tuser,   // [0] glyph_last
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [gbe_pkg::ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import gbe_pkg::*;

   localparam int CST = (COLOR_BITS < COLOR_FIELD_BITS) ? COLOR_BITS : COLOR_FIELD_BITS;

   logic [ORIGIN_BITS-1:0]   origin_x_ff, origin_x_in;
   logic [ORIGIN_BITS-1:0]   origin_y_ff, origin_y_in;
   logic [SIDE_REG_BITS-1:0] width_ff, width_in;
   logic [SIDE_REG_BITS-1:0] height_ff, height_in;
   logic [CST-1:0]           fore_ff, fore_in;
   logic [CST-1:0]           back_ff, back_in;

   logic          wr_en;
   logic [2:0]    reg_idx;
   gbe_cfg_type   cfg;
   gbe_item_type  in_item, q_item;
   logic          q_valid, q_pop;
   gbe_pixel_type pixel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[4:2];

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      fore_in     = fore_ff;
      back_in     = back_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_ORIGIN_X:     origin_x_in = csr_pwdata[ORIGIN_BITS-1:0];
            REG_ORIGIN_Y:     origin_y_in = csr_pwdata[ORIGIN_BITS-1:0];
            REG_GLYPH_WIDTH:  width_in    = csr_pwdata[SIDE_REG_BITS-1:0];
            REG_GLYPH_HEIGHT: height_in   = csr_pwdata[SIDE_REG_BITS-1:0];
            REG_FORE_COLOR:   fore_in     = csr_pwdata[CST-1:0];
            REG_BACK_COLOR:   back_in     = csr_pwdata[CST-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         width_ff    <= SIDE_RESET;
         height_ff   <= SIDE_RESET;
         fore_ff     <= FORE_RESET[CST-1:0];
         back_ff     <= BACK_RESET[CST-1:0];
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         fore_ff     <= fore_in;
         back_ff     <= back_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ORIGIN_X:     csr_prdata = 32'(origin_x_ff);
         REG_ORIGIN_Y:     csr_prdata = 32'(origin_y_ff);
         REG_GLYPH_WIDTH:  csr_prdata = 32'(width_ff);
         REG_GLYPH_HEIGHT: csr_prdata = 32'(height_ff);
         REG_FORE_COLOR:   csr_prdata = 32'(fore_ff);
         REG_BACK_COLOR:   csr_prdata = 32'(back_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.origin_x = origin_x_ff;
   assign cfg.origin_y = origin_y_ff;
   assign cfg.width    = width_ff;
   assign cfg.height   = height_ff;
   assign cfg.fore     = COLOR_FIELD_BITS'(fore_ff);
   assign cfg.back     = COLOR_FIELD_BITS'(back_ff);

   assign in_item.start = req_tuser;
   assign in_item.bits  = req_tdata;

   gbe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (in_item),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_item  (q_item)
   );

   gbe_back #(
      .MAX_SIDE (MAX_SIDE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pixel (pixel)
   );

   assign rsp_tdata = {2'b00, pixel.color, pixel.y, pixel.x};
   assign rsp_tlast = pixel.run_last;
   assign rsp_tuser = pixel.glyph_last;

endmodule

>>> tb/glyph_bitmap_expander_test.sv
module glyph_bitmap_expander_test;
   import gbe_pkg::*;

   localparam int MAX_SIDE = 64;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES = 24;
   localparam int TAIL_WORDS = 60;
   localparam int RANDOM_BYTES = 290;
   localparam int HOLD_AFTER = 400;
   localparam int HOLD_CYCLES = 150;
   localparam int PRINT_CAP = 40;

   typedef enum logic {PLAN_BYTE, PLAN_CSR} plan_kind_type;
   typedef enum logic [1:0] {CSR_WAIT, CSR_SETUP, CSR_ACCESS} csr_phase_type;

   typedef struct packed {
      plan_kind_type kind;
      logic          start;
      logic [7:0]    bits;
      logic [2:0]    reg_index;
      logic [31:0]   value;
   } plan_entry_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = 8'h00;
   logic                 req_tuser = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [47:0]          rsp_tdata;
   logic                 rsp_tlast;
   logic                 rsp_tuser;
   logic                 csr_psel = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite = 1'b0;
   logic [ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0]          csr_pwdata = 32'h0;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;

   plan_entry_type word_plan[$];
   gbe_pixel_type  expected_pixels[$];

   // predictor copy of the registers and the glyph position
   gbe_cfg_type  model_cfg;
   int unsigned  glyph_pixels;
   int unsigned  glyph_col;
   int unsigned  glyph_row;

   int            cycle_count = 0;
   int            mismatches = 0;
   int            bytes_sent = 0;
   int            pixels_seen = 0;
   int            csr_writes = 0;
   int            gap_left = 0;
   int            settle_count = 0;
   int            stall_left = 0;
   int            hold_left = 0;
   logic          hold_done = 1'b0;
   logic          quiet_tail = 1'b0;
   csr_phase_type csr_phase = CSR_WAIT;

   glyph_bitmap_expander u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   task automatic note_mismatch(input string what);
      if (mismatches < PRINT_CAP) begin
         $display("MISMATCH cycle %0d: %s", cycle_count, what);
      end
      mismatches++;
   endtask

   function automatic int unsigned clamp_side(input logic [SIDE_REG_BITS-1:0] side);
      if (side == 0) return 1;
      if (side > MAX_SIDE) return MAX_SIDE;
      return side;
   endfunction

   // expand one accepted bitmap word into the pixels it must produce
   task automatic expand_byte(input logic [7:0] bits, input logic start);
      int unsigned   w;
      int unsigned   h;
      int unsigned   total;
      int unsigned   sum_x;
      int unsigned   sum_y;
      int            b;
      int            produced;
      gbe_pixel_type px;
      gbe_pixel_type held;
      w = clamp_side(model_cfg.width);
      h = clamp_side(model_cfg.height);
      total = w * h;
      produced = 0;
      held = '0;
      if (start) begin
         glyph_pixels = 0;
         glyph_col = 0;
         glyph_row = 0;
      end
      for (b = 7; b >= 0 && glyph_pixels < total; b--) begin
         sum_x = model_cfg.origin_x + glyph_col;
         sum_y = model_cfg.origin_y + glyph_row;
         px.x = sum_x[COORD_BITS-1:0];
         px.y = sum_y[COORD_BITS-1:0];
         px.color = bits[b] ? model_cfg.fore : model_cfg.back;
         px.run_last = 1'b0;
         px.glyph_last = (glyph_pixels + 1 == total);
         if (produced > 0) expected_pixels.push_back(held);
         held = px;
         produced++;
         glyph_pixels++;
         if (!px.glyph_last) begin
            if (glyph_col + 1 >= w) begin
               glyph_col = 0;
               glyph_row++;
            end else begin
               glyph_col++;
            end
         end
      end
      if (produced > 0) begin
         held.run_last = 1'b1;
         expected_pixels.push_back(held);
      end
   endtask

   task automatic apply_register(input logic [2:0] reg_index, input logic [31:0] value);
      case (reg_index)
         REG_ORIGIN_X:     model_cfg.origin_x = value[ORIGIN_BITS-1:0];
         REG_ORIGIN_Y:     model_cfg.origin_y = value[ORIGIN_BITS-1:0];
         REG_GLYPH_WIDTH:  model_cfg.width = value[SIDE_REG_BITS-1:0];
         REG_GLYPH_HEIGHT: model_cfg.height = value[SIDE_REG_BITS-1:0];
         REG_FORE_COLOR:   model_cfg.fore = value[COLOR_FIELD_BITS-1:0];
         REG_BACK_COLOR:   model_cfg.back = value[COLOR_FIELD_BITS-1:0];
         default: ;
      endcase
   endtask

   // sender: bitmap words on req, register writes on csr once the block is idle
   always @(posedge clock) begin : word_feed
      plan_entry_type entry;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left <= 0;
         csr_phase <= CSR_WAIT;
         settle_count <= 0;
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
         model_cfg.origin_x = '0;
         model_cfg.origin_y = '0;
         model_cfg.width = SIDE_RESET;
         model_cfg.height = SIDE_RESET;
         model_cfg.fore = FORE_RESET;
         model_cfg.back = BACK_RESET;
         glyph_pixels = 0;
         glyph_col = 0;
         glyph_row = 0;
      end else begin
         quiet_tail <= (word_plan.size() < TAIL_WORDS);
         if (req_tvalid && req_tready) begin
            expand_byte(req_tdata, req_tuser);
            bytes_sent <= bytes_sent + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               req_tvalid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (word_plan.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (word_plan[0].kind == PLAN_BYTE) begin
               entry = word_plan.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= entry.bits;
               req_tuser <= entry.start;
               if (!quiet_tail && cycle_count[7:6] != 2'b11 && $urandom_range(0, 3) == 0) begin
                  gap_left <= $urandom_range(1, 5);
               end
            end else begin
               req_tvalid <= 1'b0;
               case (csr_phase)
                  CSR_WAIT: begin
                     // hold off until the engine has drained and settled
                     if (expected_pixels.size() != 0) begin
                        settle_count <= 0;
                     end else if (settle_count >= SETTLE_CYCLES) begin
                        csr_psel <= 1'b1;
                        csr_penable <= 1'b0;
                        csr_pwrite <= 1'b1;
                        csr_paddr <= {word_plan[0].reg_index, 2'b00};
                        csr_pwdata <= word_plan[0].value;
                        csr_phase <= CSR_SETUP;
                     end else begin
                        settle_count <= settle_count + 1;
                     end
                  end
                  CSR_SETUP: begin
                     csr_penable <= 1'b1;
                     csr_phase <= CSR_ACCESS;
                  end
                  CSR_ACCESS: begin
                     if (csr_pready) begin
                        entry = word_plan.pop_front();
                        apply_register(entry.reg_index, entry.value);
                        csr_writes <= csr_writes + 1;
                        csr_psel <= 1'b0;
                        csr_penable <= 1'b0;
                        csr_pwrite <= 1'b0;
                        settle_count <= 0;
                        csr_phase <= CSR_WAIT;
                     end
                  end
                  default: csr_phase <= CSR_WAIT;
               endcase
            end
         end
      end
   end

   // receiver: random stalls plus one long hold while the sender keeps offering
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && pixels_seen >= HOLD_AFTER && req_tvalid) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES - 1;
         hold_done <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet_tail && cycle_count[7:6] != 2'b01 && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : pixel_check
      gbe_pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         pixels_seen <= pixels_seen + 1;
         if (expected_pixels.size() == 0) begin
            note_mismatch($sformatf("unexpected pixel x=%0d y=%0d color=%06h",
                                    rsp_tdata[10:0], rsp_tdata[21:11], rsp_tdata[45:22]));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tdata[10:0] !== want.x)
               note_mismatch($sformatf("pixel_x %0d, want %0d", rsp_tdata[10:0], want.x));
            if (rsp_tdata[21:11] !== want.y)
               note_mismatch($sformatf("pixel_y %0d, want %0d", rsp_tdata[21:11], want.y));
            if (rsp_tdata[45:22] !== want.color)
               note_mismatch($sformatf("pixel_color %06h, want %06h",
                                       rsp_tdata[45:22], want.color));
            if (rsp_tlast !== want.run_last)
               note_mismatch($sformatf("run_last %b, want %b", rsp_tlast, want.run_last));
            if (rsp_tuser !== want.glyph_last)
               note_mismatch($sformatf("glyph_last %b, want %b", rsp_tuser, want.glyph_last));
            if (rsp_tdata[47:46] !== 2'b00)
               note_mismatch($sformatf("pad bits %b, want 00", rsp_tdata[47:46]));
         end
      end
   end

   task automatic plan_byte(input logic [7:0] bits, input logic start);
      plan_entry_type entry;
      entry = '0;
      entry.kind = PLAN_BYTE;
      entry.bits = bits;
      entry.start = start;
      word_plan.push_back(entry);
   endtask

   task automatic plan_csr(input logic [2:0] reg_index, input logic [31:0] value);
      plan_entry_type entry;
      entry = '0;
      entry.kind = PLAN_CSR;
      entry.reg_index = reg_index;
      entry.value = value;
      word_plan.push_back(entry);
   endtask

   // half the time set the unused upper bits, which the block must ignore
   function automatic logic [31:0] with_junk(input logic [31:0] field, input int bits);
      logic [31:0] junk;
      junk = $urandom_range(0, 1) ? $urandom() : 32'h0;
      return (junk & ~((32'h1 << bits) - 1)) | field;
   endfunction

   function automatic logic [SIDE_REG_BITS-1:0] pick_side();
      case ($urandom_range(0, 15))
         0: return 7'd0;
         1: return 7'($urandom_range(65, 127));
         2: return 7'd64;
         3: return 7'd1;
         4: return 7'd127;
         default: return 7'($urandom_range(1, 10));
      endcase
   endfunction

   function automatic logic [31:0] pick_origin();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'd1023;
         default: return $urandom_range(0, 1023);
      endcase
   endfunction

   function automatic logic [31:0] pick_color();
      case ($urandom_range(0, 5))
         0: return 32'h000000;
         1: return 32'hFFFFFF;
         default: return $urandom_range(0, 24'hFFFFFF);
      endcase
   endfunction

   // one setting of all registers, then glyphs until the budget is spent
   task automatic plan_random_phase(input int budget, inout int spent);
      logic [SIDE_REG_BITS-1:0] w_reg;
      logic [SIDE_REG_BITS-1:0] h_reg;
      int unsigned need;
      int          n;
      int          k;
      int          pick;
      int          used;
      w_reg = pick_side();
      h_reg = pick_side();
      // keep most glyphs short; a full 64x64 would swamp the run
      if (clamp_side(w_reg) * clamp_side(h_reg) > 512) h_reg = 7'($urandom_range(1, 8));
      plan_csr(REG_ORIGIN_X, with_junk(pick_origin(), ORIGIN_BITS));
      plan_csr(REG_ORIGIN_Y, with_junk(pick_origin(), ORIGIN_BITS));
      plan_csr(REG_GLYPH_WIDTH, with_junk(w_reg, SIDE_REG_BITS));
      plan_csr(REG_GLYPH_HEIGHT, with_junk(h_reg, SIDE_REG_BITS));
      plan_csr(REG_FORE_COLOR, with_junk(pick_color(), COLOR_FIELD_BITS));
      plan_csr(REG_BACK_COLOR, with_junk(pick_color(), COLOR_FIELD_BITS));
      need = (clamp_side(w_reg) * clamp_side(h_reg) + 7) / 8;
      used = 0;
      while (used < budget) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) n = need;
         else if (pick == 7) n = need + $urandom_range(1, 3);
         else n = $urandom_range(1, need);
         for (k = 0; k < n; k++) begin
            // noise words carry no start and continue or trail the last glyph
            plan_byte($urandom_range(0, 255), (pick != 9) && (k == 0));
         end
         used += n;
      end
      spent += used;
   endtask

   initial begin : run_control
      int random_spent;
      random_spent = 0;

      // reset settings: 8x8 glyph at the origin
      plan_byte(8'hFF, 1'b1);
      plan_byte(8'h00, 1'b0);
      plan_byte(8'hA5, 1'b0);
      plan_byte(8'h5A, 1'b0);
      plan_byte(8'h81, 1'b0);
      plan_byte(8'h7E, 1'b0);
      plan_byte(8'h01, 1'b0);
      plan_byte(8'h80, 1'b0);
      plan_byte(8'h33, 1'b0);   // glyph complete: drop
      plan_byte(8'h0F, 1'b1);
      plan_byte(8'hC3, 1'b1);   // restart mid-glyph

      // far corner, 3x3: glyph ends inside the second word
      plan_csr(REG_ORIGIN_X, with_junk(32'd1023, ORIGIN_BITS));
      plan_csr(REG_ORIGIN_Y, with_junk(32'd1023, ORIGIN_BITS));
      plan_csr(REG_GLYPH_WIDTH, 32'd3);
      plan_csr(REG_GLYPH_HEIGHT, 32'd3);
      plan_csr(REG_FORE_COLOR, with_junk(32'hFFFFFF, COLOR_FIELD_BITS));
      plan_csr(REG_BACK_COLOR, 32'h000000);
      plan_byte(8'hFF, 1'b1);
      plan_byte(8'h80, 1'b0);
      plan_byte(8'hFF, 1'b0);

      // zero width saturates up, oversize height saturates down
      plan_csr(REG_GLYPH_WIDTH, 32'd0);
      plan_csr(REG_GLYPH_HEIGHT, 32'd127);
      plan_byte(8'hAA, 1'b1);
      plan_byte(8'h55, 1'b0);

      // single-pixel glyph
      plan_csr(REG_GLYPH_WIDTH, 32'd1);
      plan_csr(REG_GLYPH_HEIGHT, 32'd1);
      plan_byte(8'h80, 1'b1);
      plan_byte(8'h7F, 1'b1);

      // narrow the box mid-glyph with the column already past the new width
      plan_csr(REG_ORIGIN_X, 32'd0);
      plan_csr(REG_ORIGIN_Y, 32'd0);
      plan_csr(REG_GLYPH_WIDTH, 32'd64);
      plan_byte(8'hF0, 1'b1);
      plan_byte(8'h0F, 1'b0);
      plan_byte(8'h3C, 1'b0);
      plan_csr(REG_GLYPH_WIDTH, 32'd5);
      plan_csr(REG_GLYPH_HEIGHT, 32'd64);
      plan_byte(8'h96, 1'b0);
      plan_byte(8'h69, 1'b0);

      // largest box, started only
      plan_csr(REG_GLYPH_WIDTH, 32'd64);
      plan_byte(8'hFF, 1'b1);
      plan_byte(8'h00, 1'b0);

      while (random_spent < RANDOM_BYTES) plan_random_phase(40, random_spent);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (word_plan.size() != 0 || req_tvalid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0)
         note_mismatch($sformatf("%0d expected pixels never arrived", expected_pixels.size()));

      $display("Sent %0d bitmap bytes and checked %0d pixels over %0d register writes,",
               bytes_sent, pixels_seen, csr_writes);
      $display("covering saturated sizes, mid-glyph resizing, restarts and output backpressure.");
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
   end

endmodule
